FILE: rtl/core/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg: shared types and constants of the size-class block allocator
// Block and page geometry, request kinds, register indices, status codes,
// sequencer states and the request and response transaction structs.
// ----------------------------------------------------------------------------
package scba_pkg;

   localparam int PAGE_BYTES      = 4096;
   localparam int MAX_PAGES       = 64;
   localparam int MIN_BLOCK_BYTES = 8;
   localparam int MAX_BLOCK_BYTES = 2048;

   localparam int TOP_BYTES   = (MAX_BLOCK_BYTES < PAGE_BYTES) ? MAX_BLOCK_BYTES : PAGE_BYTES;
   localparam int NUM_CLASSES = $clog2(TOP_BYTES / MIN_BLOCK_BYTES) + 1;
   localparam int CLASS_W     = $clog2(NUM_CLASSES + 1);
   localparam int PAGE_W      = $clog2(MAX_PAGES);
   localparam int SLOTS       = PAGE_BYTES / MIN_BLOCK_BYTES;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int BLK_W       = PAGE_W + SLOT_W;
   localparam int LINK_DEPTH  = MAX_PAGES * SLOTS;
   localparam int LEN_W       = BLK_W + 1;
   localparam int CNT_W       = SLOT_W + 1;
   localparam int QCNT_W      = PAGE_W + 1;
   localparam int MIN_SHIFT   = $clog2(MIN_BLOCK_BYTES);
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int PDATA_W     = CLASS_W + CNT_W;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [1:0] CSR_REGION_BASE  = 2'd0;
   localparam logic [1:0] CSR_REGION_PAGES = 2'd1;

   typedef logic [2:0] status_type;
   localparam status_type STATUS_OK        = 3'd0;
   localparam status_type STATUS_ZERO_SIZE = 3'd1;
   localparam status_type STATUS_NO_MEMORY = 3'd2;
   localparam status_type STATUS_TOO_LARGE = 3'd3;
   localparam status_type STATUS_BAD_ADDR  = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_CHECK,
      ST_A_QTAKE,
      ST_A_SPLIT,
      ST_A_POP,
      ST_F_RANGE,
      ST_F_PAGE,
      ST_F_ONL,
      ST_U_START,
      ST_U_WALK,
      ST_U_FIN
   } state_type;

   typedef struct packed {
      logic        req_type;
      logic [15:0] req_size;
      logic [31:0] block_addr;
   } req_type_type;

   typedef struct packed {
      logic [31:0] result_addr;
      status_type  status;
      logic        page_released;
   } rsp_type;

endpackage

FILE: rtl/core/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator: power-of-two slab allocator over a paged region
// Sequencer over list, page and free page queue memories; one transaction
// at a time.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  req      start / busy           req_data (req_type, req_size, block_addr)
//  rsp      rsp_valid strobe       rsp_data (result_addr, status, page_released)
//  csr      csr_valid / csr_ready  csr_index, csr_wdata
//
//  allocate from a non-empty list: check, then pop; an empty class takes a free page and splits
//  it into its blocks (512 >> class); an empty class with no free page moves on to the next.
//  free: range check, page lookup, on-list check, list push; a page release walks the class list.
//  reset or a write to either register reinitializes the allocator state.
//  the response strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module size_class_block_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  scba_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   output scba_pkg::rsp_type     rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);
   import scba_pkg::*;

   logic [31:0]        base_ff;
   logic [6:0]         pages_ff;
   logic [6:0]         live_ff;
   logic [6:0]         pages_new;

   logic [BLK_W-1:0]   link_mem [LINK_DEPTH];
   logic               onl_mem  [LINK_DEPTH];
   logic [PDATA_W-1:0] page_mem [MAX_PAGES];
   logic [PAGE_W-1:0]  fpq_mem  [MAX_PAGES];
   logic [MAX_PAGES-1:0] pvalid_ff;
   logic [MAX_PAGES-1:0] qvalid_ff;

   logic [BLK_W-1:0]   head_ff [NUM_CLASSES];
   logic [BLK_W-1:0]   tail_ff [NUM_CLASSES];
   logic [LEN_W-1:0]   len_ff  [NUM_CLASSES];
   logic [PAGE_W-1:0]  qhead_ff;
   logic [QCNT_W-1:0]  qcnt_ff;

   state_type          state_ff, state_in;
   logic [CLASS_W-1:0] k_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [SLOT_W-1:0]  j_ff;
   logic [31:0]        off_ff;
   logic [BLK_W-1:0]   blk_ff;
   logic [PDATA_W-1:0] pdata_ff;
   logic [BLK_W-1:0]   cur_ff;
   logic [LEN_W-1:0]   i_ff;
   logic [LEN_W-1:0]   kept_ff;
   logic [BLK_W-1:0]   nh_ff;
   logic [BLK_W-1:0]   nt_ff;

   logic [BLK_W-1:0]   link_rd_ff;
   logic               onl_rd_ff;
   logic [PDATA_W-1:0] page_rd_ff;
   logic               pv_rd_ff;
   logic [PAGE_W-1:0]  fpq_rd_ff;
   logic               qv_rd_ff;
   logic [PAGE_W-1:0]  fq_addr_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // memory controls
   logic [BLK_W-1:0]   link_raddr, link_waddr, link_wdata;
   logic               link_we;
   logic [BLK_W-1:0]   onl_raddr, onl_waddr;
   logic               onl_we, onl_wdata;
   logic [PAGE_W-1:0]  page_raddr, page_waddr;
   logic [PDATA_W-1:0] page_wdata;
   logic               page_we;
   logic               fpq_we;
   logic [PAGE_W-1:0]  fpq_waddr;

   logic               res_fire;
   logic [31:0]        res_addr;
   status_type         res_status;
   logic               res_rel;

   logic               csr_fire, init;
   logic               accept;
   logic [CLASS_W-1:0] req_class;
   logic [PDATA_W-1:0] pg;
   logic [PAGE_W-1:0]  fq;
   logic [CNT_W-1:0]   n_blk;
   logic [SLOT_W-1:0]  nm1;
   logic [BLK_W-1:0]   b_split;
   logic [CLASS_W-1:0] f_cls, f_k;
   logic [BLK_W-1:0]   b_free;
   logic [CNT_W-1:0]   cnt_inc;
   logic               keep_cur;

   assign busy      = reset || (state_ff != ST_IDLE);
   // a request offered in the same cycle goes first
   assign csr_ready = !busy && !start;
   assign csr_fire  = csr_valid & csr_ready;
   assign init      = csr_fire &&
                      (csr_index == CSR_REGION_BASE || csr_index == CSR_REGION_PAGES);
   assign accept    = start & ~busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pages_new = (csr_fire && csr_index == CSR_REGION_PAGES) ? csr_wdata[6:0] : pages_ff;

   assign pg      = pv_rd_ff ? page_rd_ff : '0;
   assign fq      = qv_rd_ff ? fpq_rd_ff : fq_addr_ff;
   assign n_blk   = CNT_W'(SLOTS) >> k_ff;
   assign nm1     = {SLOT_W{1'b1}} >> k_ff;
   assign b_split = {page_ff, SLOT_W'(j_ff << k_ff)};
   assign f_cls   = pg[PDATA_W-1:CNT_W];
   assign f_k     = f_cls - CLASS_W'(1);
   assign b_free  = {off_ff[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT],
                     off_ff[PAGE_SHIFT-1:MIN_SHIFT] & ({SLOT_W{1'b1}} << f_k)};
   assign cnt_inc = pdata_ff[CNT_W-1:0] + CNT_W'(1);
   assign keep_cur = (cur_ff[BLK_W-1:SLOT_W] != page_ff);

   // smallest class that holds the requested size
   always_comb begin
      req_class = CLASS_W'(NUM_CLASSES - 1);
      for (int c = NUM_CLASSES - 2; c >= 0; c--) begin
         if (req_data.req_size <= 16'(MIN_BLOCK_BYTES << c)) req_class = CLASS_W'(c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      link_raddr = link_rd_ff;
      link_we    = 1'b0;
      link_waddr = tail_ff[k_ff];
      link_wdata = b_split;
      onl_raddr  = b_free;
      onl_we     = 1'b0;
      onl_waddr  = b_split;
      onl_wdata  = 1'b1;
      page_raddr = off_ff[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT];
      page_we    = 1'b0;
      page_waddr = page_ff;
      page_wdata = '0;
      fpq_we     = 1'b0;
      fpq_waddr  = qhead_ff + qcnt_ff[PAGE_W-1:0];
      res_fire   = 1'b0;
      res_addr   = '0;
      res_status = STATUS_OK;
      res_rel    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == REQ_FREE) begin
                  state_in = ST_F_RANGE;
               end else if (req_data.req_size == '0) begin
                  res_fire   = 1'b1;
                  res_status = STATUS_ZERO_SIZE;
               end else if (req_data.req_size > 16'(TOP_BYTES)) begin
                  res_fire   = 1'b1;
                  res_status = STATUS_TOO_LARGE;
               end else begin
                  state_in = ST_A_CHECK;
               end
            end
         end
         ST_A_CHECK: begin
            link_raddr = head_ff[k_ff];
            page_raddr = head_ff[k_ff][BLK_W-1:SLOT_W];
            if (len_ff[k_ff] != '0) begin
               state_in = ST_A_POP;
            end else if (qcnt_ff != '0) begin
               state_in = ST_A_QTAKE;
            end else if (k_ff == CLASS_W'(NUM_CLASSES - 1)) begin
               res_fire   = 1'b1;
               res_status = STATUS_NO_MEMORY;
               state_in   = ST_IDLE;
            end
         end
         ST_A_QTAKE: begin
            state_in = ST_A_SPLIT;
         end
         ST_A_SPLIT: begin
            link_we = (len_ff[k_ff] != '0);
            onl_we  = 1'b1;
            if (j_ff == nm1) begin
               page_we    = 1'b1;
               page_wdata = {k_ff + CLASS_W'(1), n_blk};
               state_in   = ST_A_CHECK;
            end
         end
         ST_A_POP: begin
            onl_we     = 1'b1;
            onl_waddr  = head_ff[k_ff];
            onl_wdata  = 1'b0;
            page_waddr = head_ff[k_ff][BLK_W-1:SLOT_W];
            page_we    = (pg[CNT_W-1:0] != '0);
            page_wdata = {pg[PDATA_W-1:CNT_W], pg[CNT_W-1:0] - CNT_W'(1)};
            res_fire   = 1'b1;
            res_addr   = base_ff + 32'({head_ff[k_ff], {MIN_SHIFT{1'b0}}});
            state_in   = ST_IDLE;
         end
         ST_F_RANGE: begin
            if (off_ff[31:PAGE_SHIFT+PAGE_W] != '0 ||
                {1'b0, off_ff[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT]} >= live_ff) begin
               res_fire   = 1'b1;
               res_status = STATUS_BAD_ADDR;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_F_PAGE;
            end
         end
         ST_F_PAGE: begin
            if (f_cls == '0 || f_cls > CLASS_W'(NUM_CLASSES)) begin
               res_fire = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_F_ONL;
            end
         end
         ST_F_ONL: begin
            if (onl_rd_ff) begin
               res_fire = 1'b1;
               state_in = ST_IDLE;
            end else begin
               // push at the head of the class list
               link_we    = (len_ff[k_ff] != '0);
               link_waddr = blk_ff;
               link_wdata = head_ff[k_ff];
               onl_we     = 1'b1;
               onl_waddr  = blk_ff;
               if (cnt_inc >= n_blk) begin
                  state_in = ST_U_START;
               end else begin
                  page_we    = 1'b1;
                  page_wdata = {pdata_ff[PDATA_W-1:CNT_W], cnt_inc};
                  res_fire   = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_U_START: begin
            link_raddr = head_ff[k_ff];
            state_in   = ST_U_WALK;
         end
         ST_U_WALK: begin
            // relink the kept entries behind the last kept one
            link_we    = keep_cur && (kept_ff != '0);
            link_waddr = nt_ff;
            link_wdata = cur_ff;
            if (i_ff == len_ff[k_ff] - LEN_W'(1)) state_in = ST_U_FIN;
         end
         ST_U_FIN: begin
            page_we  = 1'b1;
            fpq_we   = (qcnt_ff < QCNT_W'(MAX_PAGES));
            res_fire = 1'b1;
            res_rel  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and allocator state
   always_ff @(posedge clock) begin
      if (reset || init) begin
         if (reset) begin
            base_ff  <= '0;
            pages_ff <= 7'd64;
         end else if (csr_index == CSR_REGION_BASE) begin
            base_ff  <= csr_wdata;
            pages_ff <= pages_new;
         end else begin
            pages_ff <= pages_new;
         end
         if (reset) begin
            live_ff <= QCNT_W'(MAX_PAGES);
            qcnt_ff <= QCNT_W'(MAX_PAGES);
         end else begin
            live_ff <= (pages_new > 7'(MAX_PAGES)) ? 7'(MAX_PAGES) : pages_new;
            qcnt_ff <= (pages_new > 7'(MAX_PAGES)) ? QCNT_W'(MAX_PAGES) : QCNT_W'(pages_new);
         end
         pvalid_ff <= '0;
         qvalid_ff <= '0;
         qhead_ff  <= '0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            len_ff[c] <= '0;
         end
      end else begin
         if (page_we) pvalid_ff[page_waddr] <= 1'b1;
         if (fpq_we)  qvalid_ff[fpq_waddr]  <= 1'b1;
         case (state_ff)
            ST_IDLE: begin
               k_ff   <= req_class;
               off_ff <= req_data.block_addr - base_ff;
            end
            ST_A_CHECK: begin
               if (len_ff[k_ff] == '0 && qcnt_ff == '0) k_ff <= k_ff + CLASS_W'(1);
            end
            ST_A_QTAKE: begin
               page_ff  <= fq;
               qhead_ff <= qhead_ff + PAGE_W'(1);
               qcnt_ff  <= qcnt_ff - QCNT_W'(1);
               j_ff     <= '0;
            end
            ST_A_SPLIT: begin
               if (len_ff[k_ff] == '0) head_ff[k_ff] <= b_split;
               tail_ff[k_ff] <= b_split;
               len_ff[k_ff]  <= len_ff[k_ff] + LEN_W'(1);
               j_ff          <= j_ff + SLOT_W'(1);
            end
            ST_A_POP: begin
               if (len_ff[k_ff] > LEN_W'(1)) head_ff[k_ff] <= link_rd_ff;
               len_ff[k_ff] <= len_ff[k_ff] - LEN_W'(1);
            end
            ST_F_PAGE: begin
               k_ff     <= f_k;
               blk_ff   <= b_free;
               pdata_ff <= pg;
               page_ff  <= off_ff[PAGE_SHIFT+PAGE_W-1:PAGE_SHIFT];
            end
            ST_F_ONL: begin
               if (!onl_rd_ff) begin
                  if (len_ff[k_ff] == '0) tail_ff[k_ff] <= blk_ff;
                  head_ff[k_ff] <= blk_ff;
                  len_ff[k_ff]  <= len_ff[k_ff] + LEN_W'(1);
               end
            end
            ST_U_START: begin
               cur_ff  <= head_ff[k_ff];
               i_ff    <= '0;
               kept_ff <= '0;
               nh_ff   <= '0;
               nt_ff   <= '0;
            end
            ST_U_WALK: begin
               if (keep_cur) begin
                  if (kept_ff == '0) nh_ff <= cur_ff;
                  nt_ff   <= cur_ff;
                  kept_ff <= kept_ff + LEN_W'(1);
               end
               cur_ff <= link_rd_ff;
               i_ff   <= i_ff + LEN_W'(1);
            end
            ST_U_FIN: begin
               head_ff[k_ff] <= nh_ff;
               tail_ff[k_ff] <= nt_ff;
               len_ff[k_ff]  <= kept_ff;
               if (fpq_we) qcnt_ff <= qcnt_ff + QCNT_W'(1);
            end
            default: ;
         endcase
      end
   end

   // memories, read data registered
   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      link_rd_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (onl_we) onl_mem[onl_waddr] <= onl_wdata;
      onl_rd_ff <= onl_mem[onl_raddr];
   end

   always_ff @(posedge clock) begin
      if (page_we) page_mem[page_waddr] <= page_wdata;
      page_rd_ff <= page_mem[page_raddr];
      pv_rd_ff   <= pvalid_ff[page_raddr];
   end

   always_ff @(posedge clock) begin
      if (fpq_we) fpq_mem[fpq_waddr] <= page_ff;
      fpq_rd_ff  <= fpq_mem[qhead_ff];
      qv_rd_ff   <= qvalid_ff[qhead_ff];
      fq_addr_ff <= qhead_ff;
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= res_fire;
      end
      rsp_ff.result_addr   <= res_addr;
      rsp_ff.status        <= res_status;
      rsp_ff.page_released <= res_rel;
   end

endmodule

FILE: sim/size_class_block_allocator_test.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator_test: self-checking bench of the slab allocator
// Drives allocate and free transactions through several region settings,
// predicts responses with a behavioral copy of the allocator or a directed
// row's expectation, and compares each response strobe field by field in order.
// ----------------------------------------------------------------------------
module size_class_block_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import scba_pkg::*;

   localparam int WATCHDOG_CYCLES = 400000;
   localparam int SLOT_CNT = PAGE_BYTES / MIN_BLOCK_BYTES;
   localparam int TOP_SIZE = (MAX_BLOCK_BYTES < PAGE_BYTES) ? MAX_BLOCK_BYTES : PAGE_BYTES;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_type_type req_data;
   logic         rsp_valid;
   rsp_type      rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;

   always #2 clock = ~clock;

   size_class_block_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // allocator image kept by the bench
   logic [31:0] base_q;
   int          pages_q, live_pages;
   int          num_cls;
   int          pg_class[MAX_PAGES];
   int          pg_free[MAX_PAGES];
   int          fpq[MAX_PAGES];
   int          fpq_head, fpq_cnt;
   int          next_blk[LINK_DEPTH];
   bit          on_list[LINK_DEPTH];
   int          cls_head[16], cls_tail[16], cls_len[16];
   int          granted_bytes;

   rsp_type     expected_rsps[$];
   int          mismatches = 0;
   int          idle_cycles = 0;

   typedef struct {
      logic [31:0] a;
      int          bytes;
   } held_block_t;
   held_block_t held[$];

   typedef struct {
      logic        kind;
      logic [15:0] size;
      logic [31:0] addr;
      bit          typed;
      rsp_type     rsp;
   } stim_row_t;
   stim_row_t stim_rows[$];

   function automatic void clear_allocator();
      live_pages = (pages_q > MAX_PAGES) ? MAX_PAGES : pages_q;
      for (int i = 0; i < MAX_PAGES; i++) begin
         pg_class[i] = 0;
         pg_free[i]  = 0;
         fpq[i]      = i;
      end
      for (int i = 0; i < LINK_DEPTH; i++) on_list[i] = 1'b0;
      fpq_head = 0;
      fpq_cnt  = live_pages;
      for (int i = 0; i < 16; i++) begin
         cls_head[i] = 0;
         cls_tail[i] = 0;
         cls_len[i]  = 0;
      end
      num_cls = 0;
      while (num_cls < 16 && (MIN_BLOCK_BYTES << num_cls) <= TOP_SIZE) num_cls++;
   endfunction

   function automatic void append_block(int c, int b);
      if (cls_len[c] == 0) cls_head[c] = b;
      else next_blk[cls_tail[c]] = b;
      cls_tail[c] = b;
      cls_len[c]++;
   endfunction

   // drop every block of page p from the list of class c
   function automatic void strip_page(int c, int p);
      int n, cur, kept, nh, nt, nxt;
      n = cls_len[c];
      cur = cls_head[c];
      kept = 0; nh = 0; nt = 0;
      for (int i = 0; i < n; i++) begin
         nxt = (i + 1 < n) ? next_blk[cur] : 0;
         if (cur / SLOT_CNT != p) begin
            if (kept == 0) nh = cur;
            else next_blk[nt] = cur;
            nt = cur;
            kept++;
         end else begin
            on_list[cur] = 1'b0;
         end
         cur = nxt;
      end
      cls_head[c] = nh;
      cls_tail[c] = nt;
      cls_len[c]  = kept;
   endfunction

   function automatic rsp_type allocator_step(req_type_type r);
      rsp_type     o;
      int          c, p, s, n, b, slot;
      bit          got;
      logic [31:0] off;
      o = '0;
      granted_bytes = 0;
      if (r.req_type == REQ_ALLOC) begin
         if (r.req_size == 0) o.status = STATUS_ZERO_SIZE;
         else if (r.req_size > TOP_SIZE) o.status = STATUS_TOO_LARGE;
         else begin
            c = 0;
            got = 1'b0;
            while (c + 1 < num_cls && (MIN_BLOCK_BYTES << c) < r.req_size) c++;
            for (int k = c; k < num_cls && !got; k++) begin
               if (cls_len[k] == 0 && fpq_cnt > 0) begin
                  p = fpq[fpq_head % MAX_PAGES] % MAX_PAGES;
                  s = MIN_BLOCK_BYTES << k;
                  n = PAGE_BYTES / s;
                  fpq_head = (fpq_head + 1) % MAX_PAGES;
                  fpq_cnt--;
                  for (int j = 0; j < n; j++) begin
                     b = p * SLOT_CNT + j * (s / MIN_BLOCK_BYTES);
                     append_block(k, b);
                     on_list[b] = 1'b1;
                  end
                  pg_class[p] = k + 1;
                  pg_free[p]  = n;
               end
               if (cls_len[k] > 0) begin
                  b = cls_head[k];
                  if (cls_len[k] > 1) cls_head[k] = next_blk[b];
                  cls_len[k]--;
                  p = b / SLOT_CNT;
                  on_list[b] = 1'b0;
                  if (pg_free[p] > 0) pg_free[p]--;
                  o.result_addr = base_q + 32'(b * MIN_BLOCK_BYTES);
                  granted_bytes = MIN_BLOCK_BYTES << k;
                  got = 1'b1;
               end
            end
            if (!got) o.status = STATUS_NO_MEMORY;
         end
      end else begin
         off = r.block_addr - base_q;
         if (64'(off) >= 64'(live_pages) * PAGE_BYTES) o.status = STATUS_BAD_ADDR;
         else begin
            p = off / PAGE_BYTES;
            if (pg_class[p] != 0 && pg_class[p] <= num_cls) begin
               c = pg_class[p] - 1;
               s = MIN_BLOCK_BYTES << c;
               n = PAGE_BYTES / s;
               slot = (off % PAGE_BYTES) / s;
               b = p * SLOT_CNT + slot * (s / MIN_BLOCK_BYTES);
               if (slot < n && !on_list[b]) begin
                  if (cls_len[c] == 0) cls_tail[c] = b;
                  else next_blk[b] = cls_head[c];
                  cls_head[c] = b;
                  cls_len[c]++;
                  on_list[b] = 1'b1;
                  pg_free[p]++;
                  if (pg_free[p] >= n) begin
                     strip_page(c, p);
                     pg_class[p] = 0;
                     pg_free[p]  = 0;
                     if (fpq_cnt < MAX_PAGES) begin
                        fpq[(fpq_head + fpq_cnt) % MAX_PAGES] = p;
                        fpq_cnt++;
                     end
                     o.page_released = 1'b1;
                  end
               end
            end
         end
      end
      return o;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.result_addr !== want.result_addr || rsp_data.status !== want.status ||
                rsp_data.page_released !== want.page_released) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: addr %h/%h status %0d/%0d released %b/%b (exp/act)",
                           want.result_addr, rsp_data.result_addr, want.status,
                           rsp_data.status, want.page_released, rsp_data.page_released);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic issue(logic kind, logic [15:0] size, logic [31:0] addr, int gap_pct,
                        bit typed, rsp_type typed_rsp);
      req_type_type r;
      rsp_type      p;
      held_block_t  hb;
      r.req_type = kind;
      r.req_size = size;
      r.block_addr = addr;
      start = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      p = allocator_step(r);
      expected_rsps.push_back(typed ? typed_rsp : p);
      if (kind == REQ_ALLOC && p.status == STATUS_OK) begin
         hb.a = p.result_addr;
         hb.bytes = granted_bytes;
         held.push_back(hb);
      end
      @(negedge clock);
      if ($urandom_range(99) < gap_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_REGION_BASE) base_q = data;
      else pages_q = data[6:0];
      clear_allocator();
      held.delete();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      start = 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic void add_row(logic kind, logic [15:0] size, logic [31:0] addr,
                                   bit typed, logic [31:0] ea, status_type es, logic er);
      stim_row_t row;
      row.kind = kind;
      row.size = size;
      row.addr = addr;
      row.typed = typed;
      row.rsp.result_addr = ea;
      row.rsp.status = es;
      row.rsp.page_released = er;
      stim_rows.push_back(row);
   endfunction

   task automatic random_items(int count, int gap_pct);
      int          pick, k, idx;
      logic [15:0] size;
      logic [31:0] addr;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 50 || (pick < 94 && held.size() == 0)) begin
            k = $urandom_range(0, 8);
            size = (k == 0) ? 16'($urandom_range(1, 8))
                            : 16'($urandom_range(((8 << k) / 2) + 1, 8 << k));
            issue(REQ_ALLOC, size, $urandom, gap_pct, 1'b0, '0);
         end else if (pick < 94) begin
            idx = $urandom_range(0, held.size() - 1);
            addr = held[idx].a;
            if ($urandom_range(3) == 0) addr += $urandom_range(0, held[idx].bytes - 1);
            held.delete(idx);
            issue(REQ_FREE, 16'($urandom), addr, gap_pct, 1'b0, '0);
         end else begin
            case ($urandom_range(3))
               0: issue(REQ_ALLOC, 16'($urandom), $urandom, gap_pct, 1'b0, '0);
               1: issue(REQ_ALLOC, 16'd0, $urandom, gap_pct, 1'b0, '0);
               2: issue(REQ_FREE, 16'($urandom), $urandom, gap_pct, 1'b0, '0);
               default: issue(REQ_FREE, 16'($urandom),
                              base_q + 32'($urandom_range(0, 64 * PAGE_BYTES)),
                              gap_pct, 1'b0, '0);
            endcase
         end
      end
   endtask

   initial begin
      logic [31:0] bases[5];
      int          pages[5], gaps[5], counts[5];
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_REGION_BASE;
      csr_wdata = '0;
      base_q = '0;
      pages_q = 64;
      clear_allocator();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset: base 0, 64 pages
      add_row(REQ_ALLOC, 16'd0,     32'h0, 1, 32'h0, STATUS_ZERO_SIZE, 1'b0);
      add_row(REQ_ALLOC, 16'hFFFF,  32'h0, 1, 32'h0, STATUS_TOO_LARGE, 1'b0);
      add_row(REQ_ALLOC, 16'd2049,  32'h0, 1, 32'h0, STATUS_TOO_LARGE, 1'b0);
      add_row(REQ_ALLOC, 16'd1,     32'h0, 1, 32'h0, STATUS_OK, 1'b0);
      add_row(REQ_ALLOC, 16'd8,     32'h0, 1, 32'h8, STATUS_OK, 1'b0);
      add_row(REQ_ALLOC, 16'd2048,  32'h0, 1, 32'h1000, STATUS_OK, 1'b0);
      add_row(REQ_ALLOC, 16'd9,     32'h0, 1, 32'h2000, STATUS_OK, 1'b0);
      add_row(REQ_FREE,  16'hFFFF,  32'hFFFF_FFFF, 1, 32'h0, STATUS_BAD_ADDR, 1'b0);
      add_row(REQ_FREE,  16'd0,     32'h0004_0000, 1, 32'h0, STATUS_BAD_ADDR, 1'b0);
      add_row(REQ_FREE,  16'd0,     32'h0000_A000, 1, 32'h0, STATUS_OK, 1'b0);
      add_row(REQ_FREE,  16'd0,     32'h0000_000B, 0, 32'h0, STATUS_OK, 1'b0);
      add_row(REQ_FREE,  16'd0,     32'h0000_0008, 0, 32'h0, STATUS_OK, 1'b0);
      add_row(REQ_FREE,  16'd0,     32'h0000_0000, 0, 32'h0, STATUS_OK, 1'b0);
      add_row(REQ_FREE,  16'd0,     32'h0000_1800, 0, 32'h0, STATUS_OK, 1'b0);
      add_row(REQ_FREE,  16'd0,     32'h0000_17FF, 0, 32'h0, STATUS_OK, 1'b0);
      add_row(REQ_ALLOC, 16'd4096,  32'h0, 1, 32'h0, STATUS_TOO_LARGE, 1'b0);
      add_row(REQ_ALLOC, 16'd1024,  32'h0, 0, 32'h0, STATUS_OK, 1'b0);
      add_row(REQ_ALLOC, 16'd513,   32'h0, 0, 32'h0, STATUS_OK, 1'b0);
      add_row(REQ_ALLOC, 16'd16,    32'h0, 0, 32'h0, STATUS_OK, 1'b0);
      add_row(REQ_FREE,  16'd0,     32'h0000_2010, 0, 32'h0, STATUS_OK, 1'b0);
      add_row(REQ_FREE,  16'd0,     32'h0000_2000, 0, 32'h0, STATUS_OK, 1'b0);
      foreach (stim_rows[i])
         issue(stim_rows[i].kind, stim_rows[i].size, stim_rows[i].addr, 0,
               stim_rows[i].typed, stim_rows[i].rsp);
      drain();
      held.delete();
      random_items(400, 0);

      // region settings, extremes among them; page counts above the limit clip
      bases  = '{32'h8000_0000, 32'hFFFF_F000, 32'h1234_5678, 32'h0000_1000, 32'h00AB_C000};
      pages  = '{1, 64, 2, 0, 127};
      gaps   = '{76, 0, 19, 76, 19};
      counts = '{250, 400, 300, 80, 400};
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         csr_write(CSR_REGION_BASE, bases[ph]);
         // random upper bits, page count in the low seven
         csr_write(CSR_REGION_PAGES, (32'($urandom) & 32'hFFFF_FF80) | 32'(pages[ph]));
         random_items(counts[ph], gaps[ph]);
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/scba_pkg.sv
rtl/core/size_class_block_allocator.sv
sim/size_class_block_allocator_test.sv
